@@ hdl/gnss_power_duty_scheduler_defines.svh @@
// assertion macros used by the scheduler core module
`ifndef GNSS_POWER_DUTY_SCHEDULER_DEFINES_SVH
`define GNSS_POWER_DUTY_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GPDS_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gpds same-cycle check failed");

// next-cycle implication, checked outside reset
`define GPDS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gpds next-cycle check failed");

`endif

@@ hdl/gpds_pkg.sv @@
package gpds_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned RPM_W = 16;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned CNT_W = 32;
   localparam int unsigned CSR_IDX_W = 2;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_ENGINE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FIX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SLEEP = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENGINE_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLEEP_INTERVAL = 2'd2;

   // register reset values
   localparam logic [TIME_W-1:0] ENGINE_TIMEOUT_RST = 32'd5000;
   localparam logic [TIME_W-1:0] ACTIVE_WINDOW_RST = 32'd60000;
   localparam logic [TIME_W-1:0] SLEEP_INTERVAL_RST = 32'd600000;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              speed_valid;
      logic [RPM_W-1:0]  engine_rpm;
      logic [TIME_W-1:0] speed_time_ms;
   } item_type;

   typedef struct packed {
      logic [TIME_W-1:0] engine_timeout_ms;
      logic [TIME_W-1:0] active_window_ms;
      logic [TIME_W-1:0] sleep_interval_ms;
   } cfg_type;

endpackage

@@ hdl/gpds_csr.sv @@
module gpds_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gpds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gpds_pkg::TIME_W-1:0]       csr_data,
   output gpds_pkg::cfg_type                 cfg
);
   import gpds_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   // writes are always accepted, never stalled
   assign csr_ready = 1'b1;
   assign wr = csr_valid & csr_ready;

   // register file update, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_index)
            REG_ENGINE_TIMEOUT: cfg_in.engine_timeout_ms = csr_data;
            REG_ACTIVE_WINDOW:  cfg_in.active_window_ms = csr_data;
            REG_SLEEP_INTERVAL: cfg_in.sleep_interval_ms = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.engine_timeout_ms <= ENGINE_TIMEOUT_RST;
         cfg_ff.active_window_ms <= ACTIVE_WINDOW_RST;
         cfg_ff.sleep_interval_ms <= SLEEP_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/gpds_in_stage.sv @@
module gpds_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gpds_pkg::item_type req_item,
   output logic              item_valid,
   input  logic              item_take,
   output gpds_pkg::item_type item
);
   import gpds_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // accept while empty or while the held beat moves on
   assign req_ready = ~valid_ff | item_take;
   assign load = req_valid & req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

@@ hdl/gpds_core.sv @@
`include "gnss_power_duty_scheduler_defines.svh"

module gpds_core (
   input  logic                          clock,
   input  logic                          reset,
   input  gpds_pkg::cfg_type             cfg,
   input  logic                          item_valid,
   output logic                          item_take,
   input  gpds_pkg::item_type            item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gpds_pkg::MODE_W-1:0]   rsp_mode,
   output logic                          rsp_power_on,
   output logic                          rsp_power_switch,
   output logic                          rsp_engine_on,
   output logic [gpds_pkg::CNT_W-1:0]    rsp_toggle_count,
   output logic [gpds_pkg::CNT_W-1:0]    rsp_revision_count
);
   import gpds_pkg::*;

   logic              started_ff;
   logic [TIME_W-1:0] phase_start_ff, phase_start_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              power_ff, power_in;
   logic              engine_ff, engine_in;
   logic [CNT_W-1:0]  toggles_ff, toggles_in;
   logic [CNT_W-1:0]  revisions_ff, revisions_in;
   logic              switch_ff, switch_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] age;
   logic [TIME_W-1:0] elapsed;
   logic              running;
   logic              changed;

   // the state doubles as the result register, so a beat moves only into a free slot
   assign item_take = item_valid & (~rsp_valid_ff | rsp_ready);

   // engine judgment, wrap-safe ages
   assign age = item.now_ms - item.speed_time_ms;
   assign elapsed = item.now_ms - phase_start_ff;
   assign running = item.speed_valid & (item.engine_rpm != '0) &
                    (age <= cfg.engine_timeout_ms);

   // mode transitions
   always_comb begin
      phase_start_in = phase_start_ff;
      mode_in = mode_ff;
      power_in = power_ff;
      engine_in = engine_ff;
      if (!started_ff) begin
         phase_start_in = item.now_ms;
         engine_in = running;
         mode_in = running ? MODE_ENGINE : MODE_FIX;
         power_in = 1'b1;
      end else if (running) begin
         phase_start_in = item.now_ms;
         engine_in = 1'b1;
         mode_in = MODE_ENGINE;
         power_in = 1'b1;
      end else if (mode_ff == MODE_ENGINE) begin
         phase_start_in = item.now_ms;
         engine_in = 1'b0;
         mode_in = MODE_FIX;
         power_in = 1'b1;
      end else if (mode_ff == MODE_FIX && elapsed >= cfg.active_window_ms) begin
         phase_start_in = item.now_ms;
         engine_in = 1'b0;
         mode_in = MODE_SLEEP;
         power_in = 1'b0;
      end else if (mode_ff == MODE_SLEEP && elapsed >= cfg.sleep_interval_ms) begin
         phase_start_in = item.now_ms;
         engine_in = 1'b0;
         mode_in = MODE_FIX;
         power_in = 1'b1;
      end
   end

   // counters
   assign switch_in = power_in != power_ff;
   assign changed = switch_in | (engine_in != engine_ff) | (mode_in != mode_ff);
   assign toggles_in = switch_in ? CNT_W'(toggles_ff + 1'b1) : toggles_ff;
   assign revisions_in = changed ? CNT_W'(revisions_ff + 1'b1) : revisions_ff;

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff <= 1'b0;
         phase_start_ff <= '0;
         mode_ff <= MODE_ENGINE;
         power_ff <= 1'b0;
         engine_ff <= 1'b0;
         toggles_ff <= '0;
         revisions_ff <= '0;
         switch_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            started_ff <= 1'b1;
            phase_start_ff <= phase_start_in;
            mode_ff <= mode_in;
            power_ff <= power_in;
            engine_ff <= engine_in;
            toggles_ff <= toggles_in;
            revisions_ff <= revisions_in;
            switch_ff <= switch_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mode = mode_ff;
   assign rsp_power_on = power_ff;
   assign rsp_power_switch = switch_ff;
   assign rsp_engine_on = engine_ff;
   assign rsp_toggle_count = toggles_ff;
   assign rsp_revision_count = revisions_ff;

   // checks
   `GPDS_ASSERT_NOW(a_off_only_sleeping, clock, reset, started_ff && !power_ff, mode_ff == MODE_SLEEP)
   `GPDS_ASSERT_NOW(a_engine_flag_mode, clock, reset, engine_ff, mode_ff == MODE_ENGINE)
   `GPDS_ASSERT_NEXT(a_switch_tracks_power, clock, reset, item_take, switch_ff == (power_ff != $past(power_ff)))
   `GPDS_ASSERT_NEXT(a_revision_on_mode, clock, reset, item_take && (mode_in != mode_ff), revisions_ff == CNT_W'($past(revisions_ff) + 1'b1))

endmodule

@@ hdl/gnss_power_duty_scheduler.sv @@
// channel   handshake              payload
// req       req_valid/req_ready    req_now_ms, req_speed_valid, req_engine_rpm,
//                                  req_speed_time_ms
// rsp       rsp_valid/rsp_ready    rsp_mode, rsp_power_on, rsp_power_switch,
//                                  rsp_engine_on, rsp_toggle_count, rsp_revision_count
// csr       csr_valid/csr_ready    csr_index, csr_data
//
// one beat per cycle while rsp is not stalled; a result is offered once its request
// beat has passed the input register and the state/result register
// reset is synchronous: registers return to 5000 / 60000 / 600000 ms, scheduler
// returns to its not-started state
// a stalled rsp holds its beat; req stays open while its held beat can move on
module gnss_power_duty_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gpds_pkg::TIME_W-1:0]   req_now_ms,
   input  logic                          req_speed_valid,
   input  logic [gpds_pkg::RPM_W-1:0]    req_engine_rpm,
   input  logic [gpds_pkg::TIME_W-1:0]   req_speed_time_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gpds_pkg::MODE_W-1:0]   rsp_mode,
   output logic                          rsp_power_on,
   output logic                          rsp_power_switch,
   output logic                          rsp_engine_on,
   output logic [gpds_pkg::CNT_W-1:0]    rsp_toggle_count,
   output logic [gpds_pkg::CNT_W-1:0]    rsp_revision_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gpds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gpds_pkg::TIME_W-1:0]   csr_data
);
   import gpds_pkg::*;

   cfg_type  cfg;
   item_type req_item;
   item_type item;
   logic     item_valid;
   logic     item_take;

   // pack the request beat
   assign req_item.now_ms = req_now_ms;
   assign req_item.speed_valid = req_speed_valid;
   assign req_item.engine_rpm = req_engine_rpm;
   assign req_item.speed_time_ms = req_speed_time_ms;

   gpds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gpds_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   gpds_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .item_valid         (item_valid),
      .item_take          (item_take),
      .item               (item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mode           (rsp_mode),
      .rsp_power_on       (rsp_power_on),
      .rsp_power_switch   (rsp_power_switch),
      .rsp_engine_on      (rsp_engine_on),
      .rsp_toggle_count   (rsp_toggle_count),
      .rsp_revision_count (rsp_revision_count)
   );

endmodule

@@ bench/tb_gnss_power_duty_scheduler.sv @@
`timescale 1ns / 100ps

// one snapshot beat as the block reports it
typedef struct packed {
   logic [gpds_pkg::MODE_W-1:0] mode;
   logic                        power_on;
   logic                        power_switch;
   logic                        engine_on;
   logic [gpds_pkg::CNT_W-1:0]  toggle_count;
   logic [gpds_pkg::CNT_W-1:0]  revision_count;
} duty_snapshot_type;

// duty schedule predictor plus the queue of snapshots still owed by the block
class duty_scoreboard;
   logic [gpds_pkg::TIME_W-1:0] timeout_ms;
   logic [gpds_pkg::TIME_W-1:0] window_ms;
   logic [gpds_pkg::TIME_W-1:0] interval_ms;
   logic                        started;
   logic [gpds_pkg::TIME_W-1:0] phase_start;
   logic [gpds_pkg::MODE_W-1:0] mode;
   logic                        power;
   logic                        engine;
   logic [gpds_pkg::CNT_W-1:0]  toggles;
   logic [gpds_pkg::CNT_W-1:0]  revisions;
   duty_snapshot_type           owed[$];
   int                          errors;

   function new();
      timeout_ms = gpds_pkg::ENGINE_TIMEOUT_RST;
      window_ms = gpds_pkg::ACTIVE_WINDOW_RST;
      interval_ms = gpds_pkg::SLEEP_INTERVAL_RST;
      started = 1'b0;
      phase_start = '0;
      mode = gpds_pkg::MODE_ENGINE;
      power = 1'b0;
      engine = 1'b0;
      toggles = '0;
      revisions = '0;
      errors = 0;
   endfunction

   function void write_reg(logic [gpds_pkg::CSR_IDX_W-1:0] idx,
                           logic [gpds_pkg::TIME_W-1:0] data);
      case (idx)
         gpds_pkg::REG_ENGINE_TIMEOUT: timeout_ms = data;
         gpds_pkg::REG_ACTIVE_WINDOW: window_ms = data;
         gpds_pkg::REG_SLEEP_INTERVAL: interval_ms = data;
         default: ;
      endcase
   endfunction

   function int pending();
      return owed.size();
   endfunction

   // move to a new mode / engine / power triple, counting toggles and revisions
   function void move_to(logic eng, logic [gpds_pkg::MODE_W-1:0] md, logic pwr,
                         inout logic switched);
      logic changed;
      changed = 1'b0;
      if (power != pwr) begin
         power = pwr;
         toggles = toggles + 1'b1;
         switched = 1'b1;
         changed = 1'b1;
      end
      if (engine != eng) begin
         engine = eng;
         changed = 1'b1;
      end
      if (mode != md) begin
         mode = md;
         changed = 1'b1;
      end
      if (changed)
         revisions = revisions + 1'b1;
   endfunction

   // one accepted tick: advance the schedule and queue the snapshot it yields
   function void note_tick(gpds_pkg::item_type t);
      logic [gpds_pkg::TIME_W-1:0] age;
      logic [gpds_pkg::TIME_W-1:0] elapsed;
      logic                        running;
      logic                        switched;
      duty_snapshot_type           snap;
      age = t.now_ms - t.speed_time_ms;
      running = t.speed_valid && (t.engine_rpm != '0) && (age <= timeout_ms);
      switched = 1'b0;
      if (!started) begin
         started = 1'b1;
         phase_start = t.now_ms;
         move_to(running, running ? gpds_pkg::MODE_ENGINE : gpds_pkg::MODE_FIX, 1'b1,
                 switched);
      end else if (running) begin
         phase_start = t.now_ms;
         move_to(1'b1, gpds_pkg::MODE_ENGINE, 1'b1, switched);
      end else if (mode == gpds_pkg::MODE_ENGINE) begin
         phase_start = t.now_ms;
         move_to(1'b0, gpds_pkg::MODE_FIX, 1'b1, switched);
      end else begin
         elapsed = t.now_ms - phase_start;
         if (mode == gpds_pkg::MODE_FIX && elapsed >= window_ms) begin
            phase_start = t.now_ms;
            move_to(1'b0, gpds_pkg::MODE_SLEEP, 1'b0, switched);
         end else if (mode == gpds_pkg::MODE_SLEEP && elapsed >= interval_ms) begin
            phase_start = t.now_ms;
            move_to(1'b0, gpds_pkg::MODE_FIX, 1'b1, switched);
         end
      end
      snap.mode = mode;
      snap.power_on = power;
      snap.power_switch = switched;
      snap.engine_on = engine;
      snap.toggle_count = toggles;
      snap.revision_count = revisions;
      owed.push_back(snap);
   endfunction

   task report(string msg);
      $display("error: %s", msg);
      errors++;
   endtask

   // compare one result beat against the oldest owed snapshot
   task check_snapshot(duty_snapshot_type got);
      duty_snapshot_type want;
      if (owed.size() == 0) begin
         report("result beat with no snapshot owed");
         return;
      end
      want = owed.pop_front();
      if (got.mode !== want.mode)
         report($sformatf("mode: expected %0d, got %0d", want.mode, got.mode));
      if (got.power_on !== want.power_on)
         report($sformatf("power_on: expected %0d, got %0d", want.power_on, got.power_on));
      if (got.power_switch !== want.power_switch)
         report($sformatf("power_switch: expected %0d, got %0d",
                          want.power_switch, got.power_switch));
      if (got.engine_on !== want.engine_on)
         report($sformatf("engine_on: expected %0d, got %0d", want.engine_on, got.engine_on));
      if (got.toggle_count !== want.toggle_count)
         report($sformatf("toggle_count: expected %0d, got %0d",
                          want.toggle_count, got.toggle_count));
      if (got.revision_count !== want.revision_count)
         report($sformatf("revision_count: expected %0d, got %0d",
                          want.revision_count, got.revision_count));
   endtask
endclass

module tb_gnss_power_duty_scheduler;
   import gpds_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES = 10;
   localparam int TICKS_PER_PHASE = 190;
   // index past the last register, the block must ignore it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [TIME_W-1:0] timeout;
      logic [TIME_W-1:0] window;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] step_max;
   } duty_setting_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [TIME_W-1:0]    req_now_ms = '0;
   logic                 req_speed_valid = 1'b0;
   logic [RPM_W-1:0]     req_engine_rpm = '0;
   logic [TIME_W-1:0]    req_speed_time_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [MODE_W-1:0]    rsp_mode;
   logic                 rsp_power_on;
   logic                 rsp_power_switch;
   logic                 rsp_engine_on;
   logic [CNT_W-1:0]     rsp_toggle_count;
   logic [CNT_W-1:0]     rsp_revision_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_data = '0;

   duty_scoreboard board = new();
   int                   cycle_count = 0;
   int                   stall_left = 0;
   int                   tick_count = 0;
   logic                 idle_on = 1'b1;
   logic                 engine_wanted = 1'b0;
   logic [TIME_W-1:0]    clock_ms = '0;

   gnss_power_duty_scheduler dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_now_ms(req_now_ms),
      .req_speed_valid(req_speed_valid),
      .req_engine_rpm(req_engine_rpm),
      .req_speed_time_ms(req_speed_time_ms),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_mode(rsp_mode),
      .rsp_power_on(rsp_power_on),
      .rsp_power_switch(rsp_power_switch),
      .rsp_engine_on(rsp_engine_on),
      .rsp_toggle_count(rsp_toggle_count),
      .rsp_revision_count(rsp_revision_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("gnss_power_duty_scheduler: mismatch");
         $finish;
      end
   end

   // result side stalls in random bursts between stall-free stretches
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ((cycle_count % 400) >= 100 && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check every result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_snapshot({rsp_mode, rsp_power_on, rsp_power_switch, rsp_engine_on,
                               rsp_toggle_count, rsp_revision_count});
   end

   // send one tick beat, optionally after a gap, and note it once accepted
   task automatic drive_tick(input item_type t);
      int gap;
      if (idle_on && (tick_count % 50) >= 12 && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= t.now_ms;
      req_speed_valid <= t.speed_valid;
      req_engine_rpm <= t.engine_rpm;
      req_speed_time_ms <= t.speed_time_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_tick(t);
      tick_count++;
   endtask

   task automatic send_fields(input logic [TIME_W-1:0] now, input logic valid,
                              input logic [RPM_W-1:0] rpm, input logic [TIME_W-1:0] stamp);
      item_type t;
      t.now_ms = now;
      t.speed_valid = valid;
      t.engine_rpm = rpm;
      t.speed_time_ms = stamp;
      drive_tick(t);
   endtask

   // register write beat, valid left high for a following write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
   endtask

   // stop sending and let every owed snapshot drain
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register settings per phase, extremes first
   function automatic duty_setting_type pick_setting(int phase);
      duty_setting_type s;
      case (phase)
         0: s = '{ENGINE_TIMEOUT_RST, ACTIVE_WINDOW_RST, SLEEP_INTERVAL_RST, 32'd40000};
         1: s = '{32'd0, 32'd0, 32'd0, 32'd3};
         2: s = '{'1, '1, '1, '1};
         3: s = '{32'd10, 32'd40, 32'd70, 32'd15};
         4: s = '{32'd0, '1, 32'd0, 32'd50};
         5: s = '{'1, 32'd0, '1, 32'd50};
         8: begin
            s.timeout = $urandom >> $urandom_range(0, 31);
            s.window = $urandom >> $urandom_range(0, 31);
            s.interval = $urandom >> $urandom_range(0, 31);
            s.step_max = ((s.window > s.interval ? s.window : s.interval) >> 2) + 1;
         end
         default: begin
            s.timeout = $urandom_range(0, 300);
            s.window = $urandom_range(0, 300);
            s.interval = $urandom_range(0, 300);
            s.step_max = 80;
         end
      endcase
      return s;
   endfunction

   // random tick: mostly a steady clock with sticky engine on/off stretches
   function automatic item_type make_tick(duty_setting_type s);
      item_type          t;
      logic [TIME_W-1:0] age;
      int                pick;
      if ($urandom_range(0, 19) == 0)
         engine_wanted = ~engine_wanted;
      if ($urandom_range(0, 32) == 0)
         clock_ms = $urandom;
      else
         clock_ms = clock_ms + $urandom_range(0, s.step_max);
      t.now_ms = clock_ms;
      t.speed_valid = 1'b1;
      t.engine_rpm = RPM_W'($urandom_range(1, 16'hFFFF));
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) begin
         // noise
         t.speed_valid = 1'($urandom_range(0, 1));
         t.engine_rpm = RPM_W'($urandom);
         age = $urandom;
      end else if (engine_wanted) begin
         if (pick == 0)
            age = s.timeout + 1'b1;
         else if (pick == 1)
            age = s.timeout;
         else
            age = $urandom_range(0, s.timeout);
      end else begin
         age = $urandom_range(0, s.timeout);
         if (pick < 4)
            t.speed_valid = 1'b0;
         else if (pick < 8)
            t.engine_rpm = '0;
         else
            age = s.timeout + 1'b1 + $urandom_range(0, 1000);
      end
      t.speed_time_ms = t.now_ms - age;
      return t;
   endfunction

   initial begin
      duty_setting_type  s;
      item_type          t;
      logic [TIME_W-1:0] mark;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: boundaries of age, window and interval at reset settings, across the wrap
      mark = 32'hFFFF_F000;
      send_fields(mark, 1'b1, 16'hFFFF, mark);
      send_fields(mark + 100, 1'b1, 16'd1, mark + 100 - ENGINE_TIMEOUT_RST);
      send_fields(mark + 200, 1'b1, 16'd1, mark + 200 - ENGINE_TIMEOUT_RST - 1);
      send_fields(mark + 300, 1'b0, 16'hFFFF, mark + 300);
      mark = mark + 200;
      send_fields(mark + ACTIVE_WINDOW_RST - 1, 1'b1, 16'd0, mark);
      mark = mark + ACTIVE_WINDOW_RST;
      send_fields(mark, 1'b0, 16'd0, mark);
      send_fields(mark + SLEEP_INTERVAL_RST - 1, 1'b0, 16'd7, '0);
      mark = mark + SLEEP_INTERVAL_RST;
      send_fields(mark, 1'b0, 16'd0, '1);
      send_fields(mark + 10, 1'b1, 16'd1, mark + 11);
      send_fields('1, 1'b1, 16'd1, '0);
      send_fields('0, 1'b1, 16'h8000, '1);
      send_fields(32'd5, 1'b0, 16'd1, 32'd5);
      clock_ms = 32'd5;

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         drain();
         s = pick_setting(p);
         csr_write(REG_ENGINE_TIMEOUT, s.timeout);
         csr_write(REG_ACTIVE_WINDOW, s.window);
         csr_write(REG_SLEEP_INTERVAL, s.interval);
         csr_write(REG_UNUSED, $urandom);
         csr_valid <= 1'b0;
         if (p == PHASES - 1)
            idle_on = 1'b0;
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            t = make_tick(s);
            drive_tick(t);
         end
      end

      // let the tail drain, then wait on for stray beats
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("gnss_power_duty_scheduler: match");
      else
         $display("gnss_power_duty_scheduler: mismatch");
      $finish;
   end
endmodule
